[src/kart_pkg.sv]
// Shared types, constants and helpers for the key auto-release tracker.
package kart_pkg;

  localparam int unsigned KeyCountDef   = 128;
  localparam int unsigned QueueDepthDef = 256;

  localparam int unsigned CodeW     = 7;
  localparam int unsigned FrameW    = 32;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned HoldW     = 6;
  localparam int unsigned HoldFrW   = 3;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 7;
  localparam int unsigned HoldDiv   = 9;

  // Operation codes
  localparam logic [1:0] OpPress  = 2'd0;
  localparam logic [1:0] OpExpire = 2'd1;
  localparam logic [1:0] OpPop    = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] CfgTapHold    = 3'd0;
  localparam logic [CfgIndexW-1:0] CfgRepeatHold = 3'd1;
  localparam logic [CfgIndexW-1:0] CfgTurnHold   = 3'd2;
  localparam logic [CfgIndexW-1:0] CfgTurnLeft   = 3'd3;
  localparam logic [CfgIndexW-1:0] CfgTurnRight  = 3'd4;

  localparam logic [HoldW-1:0] TapHoldRst    = 6'd9;
  localparam logic [HoldW-1:0] RepeatHoldRst = 6'd9;
  localparam logic [HoldW-1:0] TurnHoldRst   = 6'd27;
  localparam logic [CodeW-1:0] TurnLeftRst   = 7'd107;
  localparam logic [CodeW-1:0] TurnRightRst  = 7'd108;

  localparam logic [ByteW-1:0] ReleaseBit = 8'h80;

  typedef struct packed {
    logic [1:0]        op;
    logic [CodeW-1:0]  key_code;
    logic [FrameW-1:0] frame;
  } in_t;

  typedef struct packed {
    logic [ByteW-1:0] event_byte;
    logic             queue_not_empty;
  } out_t;

  typedef struct packed {
    logic             push;
    logic [ByteW-1:0] push_byte;
    logic             pop;
  } fifo_req_t;

  typedef struct packed {
    logic             not_empty;
    logic [ByteW-1:0] rd_byte;
  } fifo_sts_t;

  typedef enum logic [6:0] {
    StIdle    = 7'b0000001,
    StPress   = 7'b0000010,
    StScan    = 7'b0000100,
    StTail    = 7'b0001000,
    StPop     = 7'b0010000,
    StPopWait = 7'b0100000,
    StDone    = 7'b1000000
  } state_e;

  // Frames of hold beyond the first: slider value divided by nine
  function automatic logic [HoldFrW-1:0] hold_frames(input logic [HoldW-1:0] h);
    logic [HoldFrW-1:0] q;
    q = '0;
    for (int i = 1; i <= 7; i++) begin
      if (int'(h) >= i * HoldDiv) begin
        q = HoldFrW'(i);
      end
    end
    return q;
  endfunction

endpackage

[src/kart_frame_ram.sv]
// Release-frame memory: one write port, one registered read port.
module kart_frame_ram #(
  parameter int unsigned Depth = kart_pkg::KeyCountDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [kart_pkg::FrameW-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [kart_pkg::FrameW-1:0] rdata_o
);

  logic [kart_pkg::FrameW-1:0] mem_q [Depth];
  logic [kart_pkg::FrameW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/kart_event_fifo.sv]
// Event word FIFO on a synchronous memory; pushes into a full queue are dropped.
module kart_event_fifo #(
  parameter int unsigned QueueDepth = kart_pkg::QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kart_pkg::fifo_req_t req_i,
  output kart_pkg::fifo_sts_t sts_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);

  logic [kart_pkg::ByteW-1:0] mem_q [QueueDepth];
  logic [kart_pkg::ByteW-1:0] rd_byte_q;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] wr_next, rd_next;
  logic            empty, full, do_push, do_pop;

  assign wr_next = (wr_ptr_q == PtrLast) ? '0 : PtrW'(wr_ptr_q + 1'b1);
  assign rd_next = (rd_ptr_q == PtrLast) ? '0 : PtrW'(rd_ptr_q + 1'b1);
  assign empty   = (rd_ptr_q == wr_ptr_q);
  assign full    = (wr_next == rd_ptr_q);
  assign do_push = req_i.push && !full;
  assign do_pop  = req_i.pop && !empty;

  assign wr_ptr_d = do_push ? wr_next : wr_ptr_q;
  assign rd_ptr_d = do_pop ? rd_next : rd_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= req_i.push_byte;
    end
    if (do_pop) begin
      rd_byte_q <= mem_q[rd_ptr_q];
    end
  end

  assign sts_o.not_empty = !empty;
  assign sts_o.rd_byte   = rd_byte_q;

endmodule

[src/key_auto_release_tracker.sv]
// Key auto-release tracker: sequencer, hold registers and key-down bits.
//
// Usage: one input word (op, key_code, frame) per item on in_valid_i/in_ready_o
// gives exactly one result word (event_byte, queue_not_empty) on out_valid_o/
// out_ready_i. Configuration writes arrive on cfg_valid_i/cfg_ready_o with
// cfg_index_i selecting tap, repeat, turn hold, left and right turn code; the
// port is always ready and should be used only while the block is idle.
// Items are handled one at a time. A press passes through StPress and a pop through
// StPop and StPopWait before StDone; an expire walks keys 1 to KEY_COUNT-1 through
// the release-frame memory one entry per cycle, then StTail and StDone. In_ready_o
// rises again in the cycle after
// the result is loaded into the output register, so the next item is taken
// while that result still waits for the receiver. A stalled receiver holds the
// output register; the sequencer then waits to load the next result.
// Reset clears the key-down bits, the queue pointers and restores the default
// hold registers; it needs no clearing pass.
module key_auto_release_tracker #(
  parameter int unsigned KEY_COUNT   = kart_pkg::KeyCountDef,
  parameter int unsigned QUEUE_DEPTH = kart_pkg::QueueDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  kart_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output kart_pkg::out_t                    out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [kart_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  logic [kart_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned KeyW = $clog2(KEY_COUNT);
  localparam logic [KeyW-1:0] KeyLast = KeyW'(KEY_COUNT - 1);

  kart_pkg::state_e state_q, state_d;

  logic [kart_pkg::HoldW-1:0] tap_q, repeat_q, turn_q;
  logic [kart_pkg::CodeW-1:0] left_q, right_q;

  kart_pkg::in_t               item_q;
  logic [KEY_COUNT-1:0]        down_q;
  logic [KeyW-1:0]             scan_idx_q, chk_idx_q;
  logic                        chk_vld_q;
  logic                        pop_hit_q;
  logic [kart_pkg::ByteW-1:0]  ev_q;
  logic                        out_valid_q;
  kart_pkg::out_t              out_q;

  kart_pkg::fifo_req_t fifo_req;
  kart_pkg::fifo_sts_t fifo_sts;

  logic [KeyW-1:0]              key_idx;
  logic                         key_ok;
  logic [kart_pkg::HoldW-1:0]   hold;
  logic [kart_pkg::FrameW-1:0]  rel_frame;
  logic [kart_pkg::FrameW-1:0]  ram_rdata;
  logic [kart_pkg::FrameW-1:0]  diff;
  logic                         chk_due;
  logic                         in_acc, out_free, scanning;

  assign in_acc      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == kart_pkg::StIdle);
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign scanning    = (state_q == kart_pkg::StScan) || (state_q == kart_pkg::StTail);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q    <= kart_pkg::TapHoldRst;
      repeat_q <= kart_pkg::RepeatHoldRst;
      turn_q   <= kart_pkg::TurnHoldRst;
      left_q   <= kart_pkg::TurnLeftRst;
      right_q  <= kart_pkg::TurnRightRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        kart_pkg::CfgTapHold:    tap_q    <= cfg_data_i[kart_pkg::HoldW-1:0];
        kart_pkg::CfgRepeatHold: repeat_q <= cfg_data_i[kart_pkg::HoldW-1:0];
        kart_pkg::CfgTurnHold:   turn_q   <= cfg_data_i[kart_pkg::HoldW-1:0];
        kart_pkg::CfgTurnLeft:   left_q   <= cfg_data_i;
        kart_pkg::CfgTurnRight:  right_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Press: pick the hold and arm the release frame
  assign key_idx = item_q.key_code[KeyW-1:0];
  assign key_ok  = (item_q.key_code != '0) && (int'(item_q.key_code) < KEY_COUNT);

  always_comb begin
    if (item_q.key_code == left_q || item_q.key_code == right_q) begin
      hold = turn_q;
    end else if (down_q[key_idx]) begin
      hold = repeat_q;
    end else begin
      hold = tap_q;
    end
  end

  assign rel_frame = item_q.frame + kart_pkg::FrameW'(kart_pkg::hold_frames(hold))
                     + kart_pkg::FrameW'(1);

  // Expire: check the entry read in the previous cycle
  assign diff    = item_q.frame - ram_rdata;
  assign chk_due = chk_vld_q && down_q[chk_idx_q] && !diff[kart_pkg::FrameW-1];

  always_comb begin
    fifo_req.push      = 1'b0;
    fifo_req.push_byte = '0;
    fifo_req.pop       = (state_q == kart_pkg::StPop) && fifo_sts.not_empty;
    if (state_q == kart_pkg::StPress && key_ok) begin
      fifo_req.push      = 1'b1;
      fifo_req.push_byte = {1'b0, item_q.key_code};
    end else if (chk_due) begin
      fifo_req.push      = 1'b1;
      fifo_req.push_byte = kart_pkg::ReleaseBit | kart_pkg::ByteW'(chk_idx_q);
    end
  end

  kart_frame_ram #(
    .Depth (KEY_COUNT),
    .AddrW (KeyW)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    ((state_q == kart_pkg::StPress) && key_ok),
    .waddr_i (key_idx),
    .wdata_i (rel_frame),
    .re_i    (state_q == kart_pkg::StScan),
    .raddr_i (scan_idx_q),
    .rdata_o (ram_rdata)
  );

  kart_event_fifo #(
    .QueueDepth (QUEUE_DEPTH)
  ) u_event_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fifo_req),
    .sts_o  (fifo_sts)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      kart_pkg::StIdle: begin
        if (in_acc) begin
          if (in_data_i.op == kart_pkg::OpPress) begin
            state_d = kart_pkg::StPress;
          end else if (in_data_i.op == kart_pkg::OpExpire) begin
            state_d = kart_pkg::StScan;
          end else if (in_data_i.op == kart_pkg::OpPop) begin
            state_d = kart_pkg::StPop;
          end else begin
            state_d = kart_pkg::StDone;
          end
        end
      end
      kart_pkg::StPress:   state_d = kart_pkg::StDone;
      kart_pkg::StScan: begin
        if (scan_idx_q == KeyLast) begin
          state_d = kart_pkg::StTail;
        end
      end
      kart_pkg::StTail:    state_d = kart_pkg::StDone;
      kart_pkg::StPop:     state_d = kart_pkg::StPopWait;
      kart_pkg::StPopWait: state_d = kart_pkg::StDone;
      kart_pkg::StDone: begin
        if (out_free) begin
          state_d = kart_pkg::StIdle;
        end
      end
      default:             state_d = kart_pkg::StIdle;
    endcase
    // Drop a press with code zero or beyond the key table
    if (state_q == kart_pkg::StPress && !key_ok) begin
      state_d = kart_pkg::StDone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kart_pkg::StIdle;
      down_q      <= '0;
      scan_idx_q  <= '0;
      chk_vld_q   <= 1'b0;
      pop_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      chk_vld_q <= (state_q == kart_pkg::StScan);
      pop_hit_q <= fifo_req.pop;
      if (state_q == kart_pkg::StPress && key_ok) begin
        down_q[key_idx] <= 1'b1;
      end
      if (chk_due) begin
        down_q[chk_idx_q] <= 1'b0;
      end
      if (in_acc) begin
        scan_idx_q <= KeyW'(1);
      end else if (state_q == kart_pkg::StScan) begin
        scan_idx_q <= KeyW'(scan_idx_q + 1'b1);
      end
      if (state_q == kart_pkg::StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= scan_idx_q;
    if (in_acc) begin
      item_q <= in_data_i;
      ev_q   <= '0;
    end else if (state_q == kart_pkg::StPopWait) begin
      ev_q <= pop_hit_q ? fifo_sts.rd_byte : '0;
    end
    if (state_q == kart_pkg::StDone && out_free) begin
      out_q.event_byte      <= ev_q;
      out_q.queue_not_empty <= fifo_sts.not_empty;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // An accepted item always leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != kart_pkg::StIdle)
    else $error("accepted item did not start");

  // Pushes happen only while pressing or scanning
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_req.push |-> (state_q == kart_pkg::StPress) || scanning)
    else $error("queue push outside press or scan");

  // The scan never checks key zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kart_pkg::StScan) |-> scan_idx_q != '0)
    else $error("scan index out of range");

  // A result is loaded only when the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kart_pkg::StDone) && !out_free |=> state_q == kart_pkg::StDone)
    else $error("result lost while receiver stalled");
`endif

endmodule
